// ----- sv/ptt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_pkg: shared types and constants
// Widths and limits for the power tower of two modulo n block.
// ----------------------------------------------------------------------------
package ptt_pkg;
    localparam int ModBits   = 24;
    localparam int MaxDepth  = 64;
    localparam int DepthBits = $clog2(MaxDepth + 1);

    typedef logic [ModBits-1:0] mod_t;

    // One entry of the chain: a level and its totient.
    typedef struct packed {
        mod_t level;
        mod_t tot;
    } link_t;

    // Job header passed from the front to the back.
    typedef struct packed {
        logic                 trivial;
        logic [DepthBits-1:0] depth;
    } job_t;
endpackage

// ----- sv/ptt_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_if: valid/ready channel
// Carries one 24-bit word per beat.
// ----------------------------------------------------------------------------
interface ptt_if import ptt_pkg::*; ();
    logic valid;
    logic ready;
    mod_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- sv/ptt_divmod.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_divmod: iterative divider
// Restoring division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ptt_divmod import ptt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [2*ModBits-1:0] dividend,
    input  mod_t                 divisor,
    output logic                 done,
    output logic [2*ModBits-1:0] quotient,
    output mod_t                 remainder
);
    localparam int W = 2 * ModBits;
    logic [W-1:0]          q_reg, q_next;
    logic [ModBits:0]      r_reg, r_next;
    logic [$clog2(W+1)-1:0] cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    mod_t                  d_reg, d_next;
    logic [ModBits+1:0]    trial;

    // One shift-subtract step per cycle.
    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        d_next = d_reg;
        done_next = 1'b0;
        trial = '0;
        if (start)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = ($clog2(W+1))'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            trial = {r_reg, q_reg[W-1]} - {2'b00, d_reg};
            if (!trial[ModBits+1])
            begin
                r_next = trial[ModBits:0];
                q_next = {q_reg[W-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[ModBits-1:0], q_reg[W-1]};
                q_next = {q_reg[W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quotient = q_reg;
    assign remainder = r_reg[ModBits-1:0];
endmodule

// ----- sv/ptt_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_front: chain builder
// Accepts a modulus, writes the chain of totients into the chain memory and pushes a job into the queue.
// ----------------------------------------------------------------------------
module ptt_front import ptt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    ptt_if.sink                  in_ch,
    output logic                 job_valid,
    output job_t                 job,
    input  logic                 job_ready,
    input  logic                 chain_free,
    output logic                 link_we,
    output logic [DepthBits-1:0] link_addr,
    output link_t                link_data
);
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_TRY   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_STEP  = 7'b0010000,
        S_LINK  = 7'b0100000,
        S_PUSH  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    mod_t                 m_reg, m_next;
    mod_t                 rest_reg, rest_next;
    mod_t                 tot_reg, tot_next;
    mod_t                 d_reg, d_next;
    logic                 hit_reg, hit_next;
    logic [DepthBits-1:0] depth_reg, depth_next;
    logic                 triv_reg, triv_next;
    logic [2*ModBits-1:0] dd_reg;
    logic                 div_start, div_done;
    logic [2*ModBits-1:0] div_q;
    mod_t                 div_r;
    logic [2*ModBits-1:0] tmul;

    ptt_divmod u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend({{ModBits{1'b0}}, rest_reg}), .divisor(d_reg),
        .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    assign tmul = tot_reg * (hit_reg ? d_reg : d_reg - 1'b1);

    // Trial division sequencer.
    always_comb
    begin
        state_next = state_reg;
        m_next = m_reg;
        rest_next = rest_reg;
        tot_next = tot_reg;
        d_next = d_reg;
        hit_next = hit_reg;
        depth_next = depth_reg;
        triv_next = triv_reg;
        div_start = 1'b0;
        link_we = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_ch.valid)
                begin
                    m_next = in_ch.data;
                    depth_next = '0;
                    triv_next = (in_ch.data <= 1);
                    state_next = (in_ch.data <= 1) ? S_PUSH : S_START;
                end
            end
            S_START:
            begin
                rest_next = m_reg;
                tot_next = mod_t'(1);
                d_next = mod_t'(2);
                hit_next = 1'b0;
                state_next = S_TRY;
            end
            S_TRY:
            begin
                // After a hit the same divisor is tried again until it fails.
                if (!hit_reg && dd_reg > {{ModBits{1'b0}}, rest_reg})
                begin
                    if (rest_reg > 1)
                        tot_next = ModBits'(tot_reg * (rest_reg - 1'b1));
                    state_next = S_LINK;
                end
                else
                begin
                    div_start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                if (div_r == '0)
                begin
                    rest_next = div_q[ModBits-1:0];
                    tot_next = tmul[ModBits-1:0];
                    hit_next = 1'b1;
                    div_start = 1'b0;
                    state_next = S_TRY;
                    if (div_q[ModBits-1:0] < d_reg)
                        state_next = S_TRY;
                end
                else
                begin
                    d_next = d_reg + 1'b1;
                    hit_next = 1'b0;
                    state_next = S_TRY;
                end
            end
            S_LINK:
            begin
                // The chain memory is written only once the back has let go of it.
                if (chain_free)
                begin
                    link_we = 1'b1;
                    depth_next = depth_reg + 1'b1;
                    m_next = tot_reg;
                    if (tot_reg > 1 && depth_reg + 1'b1 < DepthBits'(MaxDepth))
                        state_next = S_START;
                    else
                        state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                if (job_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        m_reg <= m_next;
        rest_reg <= rest_next;
        tot_reg <= tot_next;
        d_reg <= d_next;
        hit_reg <= hit_next;
        depth_reg <= depth_next;
        triv_reg <= triv_next;
        dd_reg <= d_next * d_next;
    end

    assign in_ch.ready = (state_reg == S_IDLE);
    assign job_valid = (state_reg == S_PUSH);
    assign job.trivial = triv_reg;
    assign job.depth = depth_reg;
    assign link_addr = depth_reg;
    assign link_data.level = m_reg;
    assign link_data.tot = tot_reg;
endmodule

// ----- sv/ptt_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_back: tower evaluator
// Walks the chain upward and raises two to each level's exponent.
// ----------------------------------------------------------------------------
module ptt_back import ptt_pkg::*; (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 job_valid,
    input  job_t                 job,
    output logic                 job_ready,
    output logic [DepthBits-1:0] link_addr,
    input  link_t                link_rd,
    ptt_if.source                out_ch
);
    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_LOAD = 7'b0000100,
        S_BIT  = 7'b0001000,
        S_MUL  = 7'b0010000,
        S_NEXT = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t               state_reg, state_next;
    logic [DepthBits-1:0] k_reg, k_next;
    mod_t                 below_reg, below_next;
    mod_t                 mod_reg, mod_next;
    logic [ModBits:0]     e_reg, e_next;
    mod_t                 acc_reg, acc_next;
    mod_t                 b_reg, b_next;
    logic                 phase_reg, phase_next;
    logic                 div_start, div_done;
    logic                 div_busy_reg;
    logic [2*ModBits-1:0] div_q, prod_reg, prod_next;
    mod_t                 div_r;

    ptt_divmod u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(prod_reg),
        .divisor(mod_reg), .done(div_done), .quotient(div_q), .remainder(div_r)
    );

    // Square-and-multiply; phase 0 is the multiply into acc, phase 1 the square.
    always_comb
    begin
        state_next = state_reg;
        k_next = k_reg;
        below_next = below_reg;
        mod_next = mod_reg;
        e_next = e_reg;
        acc_next = acc_reg;
        b_next = b_reg;
        phase_next = phase_reg;
        prod_next = prod_reg;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (job_valid)
                begin
                    below_next = '0;
                    k_next = job.depth;
                    state_next = job.trivial ? S_OUT : S_NEXT;
                end
            end
            S_NEXT:
            begin
                if (k_reg == '0)
                    state_next = S_OUT;
                else
                begin
                    k_next = k_reg - 1'b1;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_LOAD;
            end
            S_LOAD:
            begin
                mod_next = link_rd.level;
                e_next = {1'b0, below_reg} + {1'b0, link_rd.tot};
                acc_next = mod_t'(1);
                b_next = (link_rd.level == 2) ? '0 : mod_t'(2);
                state_next = S_BIT;
            end
            S_BIT:
            begin
                if (e_reg == '0)
                begin
                    below_next = acc_reg;
                    state_next = S_NEXT;
                end
                else
                begin
                    phase_next = ~e_reg[0];
                    prod_next = e_reg[0] ? acc_reg * b_reg : b_reg * b_reg;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // Start a reduction whenever the divider is free.
                div_start = !div_busy_reg;
                if (div_done)
                begin
                    if (!phase_reg)
                    begin
                        acc_next = div_r;
                        phase_next = 1'b1;
                        prod_next = b_reg * b_reg;
                    end
                    else
                    begin
                        b_next = div_r;
                        e_next = e_reg >> 1;
                        state_next = S_BIT;
                    end
                end
            end
            S_OUT:
            begin
                if (out_ch.ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Tracks a reduction in progress.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_busy_reg <= 1'b0;
        else if (div_done)
            div_busy_reg <= 1'b0;
        else if (div_start)
            div_busy_reg <= 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        below_reg <= below_next;
        mod_reg <= mod_next;
        e_reg <= e_next;
        acc_reg <= acc_next;
        b_reg <= b_next;
        phase_reg <= phase_next;
        prod_reg <= prod_next;
    end

    assign job_ready = (state_reg == S_IDLE);
    assign link_addr = k_reg;
    assign out_ch.valid = (state_reg == S_OUT);
    assign out_ch.data = below_reg;
endmodule

// ----- sv/power_tower_two_mod_n_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_tower_two_mod_n_core: tower of twos modulo n
// Returns 2^2^2^... mod n for each modulus beat.
// ----------------------------------------------------------------------------
// Usage:
// in_ch carries one modulus per beat; out_ch returns one tower value per beat.
// The front builds the chain n, phi(n), ... by trial division, using a
// bit-serial divider, and writes it into a chain memory.
// The back walks that chain upward and runs square-and-multiply with its own
// 48-step divider. A one-entry job queue lets the front start building the
// next chain while the back still evaluates; the front writes the chain
// memory only once the back is idle.
// Reset clears both sequencers; no clearing pass is needed.
// A stalled receiver holds the result, and the back takes no new job.
// ----------------------------------------------------------------------------
module power_tower_two_mod_n_core import ptt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    ptt_if.sink   in_ch,
    ptt_if.source out_ch
);
    logic                 f_valid, f_ready, b_valid, b_ready;
    logic                 chain_free;
    job_t                 f_job, q_job;
    logic                 link_we;
    logic [DepthBits-1:0] w_addr, r_addr;
    link_t                w_data, r_data;
    link_t                chain_mem [MaxDepth];
    logic                 q_full_reg;

    ptt_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .job_valid(f_valid), .job(f_job),
        .job_ready(f_ready), .chain_free(chain_free), .link_we(link_we),
        .link_addr(w_addr), .link_data(w_data)
    );

    // The chain memory is owned by one job at a time: the front only writes
    // while no job is queued and the back is idle.
    always_ff @(posedge clk)
    begin
        if (link_we)
            chain_mem[w_addr[$clog2(MaxDepth)-1:0]] <= w_data;
        r_data <= chain_mem[r_addr[$clog2(MaxDepth)-1:0]];
    end

    // Job queue: one entry between front and back.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_full_reg <= 1'b0;
        else if (f_valid && f_ready)
            q_full_reg <= 1'b1;
        else if (b_valid && b_ready)
            q_full_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (f_valid && f_ready)
            q_job <= f_job;
    end

    assign chain_free = !q_full_reg && b_ready;
    assign f_ready = !q_full_reg && b_ready;
    assign b_valid = q_full_reg;

    ptt_back u_back (
        .clk(clk), .rst_n(rst_n), .job_valid(b_valid), .job(q_job),
        .job_ready(b_ready), .link_addr(r_addr), .link_rd(r_data), .out_ch(out_ch)
    );

    // A result stays offered until taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.data))
        else $error("result dropped while stalled");
    // The front never writes the chain while a job is queued or evaluated.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        link_we |-> !q_full_reg && b_ready)
        else $error("chain written while in use");
endmodule

// ----- bench/ptt_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptt_checker: result predictor and scoreboard
// Watches both channels of the tower block. Each accepted modulus beat is
// turned into an expected tower value. Each result beat is compared with
// the oldest expected value.
// ----------------------------------------------------------------------------
module ptt_checker import ptt_pkg::*; (
    input  logic clk,
    input  logic rst_n,
    ptt_if       in_ch,
    ptt_if       out_ch,
    output int   fail_count,
    output int   pending
);
    mod_t tower_q[$];

    // Euler totient by trial division over every integer.
    function automatic longint unsigned totient(longint unsigned m);
        longint unsigned rest;
        longint unsigned res;
        longint unsigned d;
        rest = m;
        res = 1;
        for (d = 2; d * d <= rest; d++)
        begin
            if (rest % d == 0)
            begin
                rest = rest / d;
                res = res * (d - 1);
                while (rest % d == 0)
                begin
                    rest = rest / d;
                    res = res * d;
                end
            end
        end
        if (rest > 1)
            res = res * (rest - 1);
        return res;
    endfunction

    // Square-and-multiply for 2^e mod m.
    function automatic longint unsigned two_pow_mod(longint unsigned e, longint unsigned m);
        longint unsigned acc;
        longint unsigned b;
        acc = 1 % m;
        b = 2 % m;
        while (e != 0)
        begin
            if (e[0])
                acc = (acc * b) % m;
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc;
    endfunction

    // Builds the totient chain, then walks it back up.
    function automatic mod_t tower_of_two(mod_t modulus);
        longint unsigned lvl[MaxDepth];
        longint unsigned tot[MaxDepth];
        longint unsigned n;
        longint unsigned below;
        int depth;
        n = modulus;
        below = 0;
        depth = 0;
        if (n <= 1)
            return '0;
        while (n > 1 && depth < MaxDepth)
        begin
            lvl[depth] = n;
            tot[depth] = totient(n);
            n = tot[depth];
            depth++;
        end
        for (int k = depth - 1; k >= 0; k--)
            below = two_pow_mod(below + tot[k], lvl[k]);
        return mod_t'(below);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        mod_t want;
        if (!rst_n)
        begin
            fail_count <= 0;
            pending <= 0;
        end
        else
        begin
            // Modulus beat: queue the expected tower value.
            if (in_ch.valid && in_ch.ready)
                tower_q.push_back(tower_of_two(in_ch.data));
            // Result beat: compare with the oldest expectation.
            if (out_ch.valid && out_ch.ready)
            begin
                if (tower_q.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected result beat: tower_value=%0d", out_ch.data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = tower_q.pop_front();
                    if (want !== out_ch.data)
                    begin
                        if (fail_count < 10)
                            $display("tower_value mismatch: expected %0d, got %0d",
                                     want, out_ch.data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= tower_q.size();
        end
    end
endmodule

// ----- bench/power_tower_two_mod_n_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_tower_two_mod_n_core_tb: testbench top
// Drives moduli into the tower block with random gaps and random result
// stalls, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module power_tower_two_mod_n_core_tb;
    import ptt_pkg::*;

    logic clk;
    logic rst_n;
    int   fail_count;
    int   pending;

    ptt_if in_ch();
    ptt_if out_ch();

    power_tower_two_mod_n_core uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    ptt_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // 12 ns clock.
    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // Sends one modulus beat after a random gap; valid stays high with no gap.
    task automatic send_modulus(input mod_t modulus);
        int gap;
        gap = $urandom_range(0, 11);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= modulus;
        @(posedge clk iff in_ch.ready);
    endtask

    // Result side: a random stall before each beat.
    initial
    begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            stall = $urandom_range(0, 11);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk iff out_ch.valid);
        end
    end

    // Stimulus and verdict.
    initial
    begin
        mod_t corner[$];
        int pick;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Trivial, small, and wide moduli with every bit toggled.
        corner = '{24'd0, 24'd1, 24'd2, 24'd3, 24'd4, 24'd5, 24'd6, 24'd7, 24'd8,
                   24'd9, 24'd12, 24'd16, 24'd100, 24'd255, 24'd256, 24'd1000,
                   24'd65536, 24'hFFFFFF, 24'h800000, 24'h7FFFFF, 24'hAAAAAA,
                   24'h555555, 24'd16777213};
        foreach (corner[i])
            send_modulus(corner[i]);

        // Hold off until every outstanding tower value is back.
        in_ch.valid <= 1'b0;
        @(posedge clk iff pending == 0);

        // Random moduli, mostly small to keep the trial division short.
        for (int i = 0; i < 80; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 3)
                send_modulus(mod_t'($urandom_range(0, 1)));
            else if (pick < 13)
                send_modulus(mod_t'($urandom_range(2, 65535)));
            else
                send_modulus(mod_t'($urandom_range(2, 300)));
        end
        in_ch.valid <= 1'b0;

        @(posedge clk iff pending == 0);
        repeat (200) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #1_000_000_000;
        $display("status: fail");
        $finish;
    end
endmodule
